FILE: design/ifla_pkg.sv
// Shared types, codes and constants for the indexed free-list allocator.
// No dependencies; used by ifla_link_ram and indexed_free_list_allocator.
`default_nettype none

package ifla_pkg;

  localparam int INDEX_W    = 8;
  localparam int LINK_DEPTH = 255;
  localparam int STATUS_W   = 2;

  localparam logic [INDEX_W-1:0] END_INDEX      = 8'd255;
  localparam logic [INDEX_W-1:0] COUNT_MAX      = 8'd255;
  localparam logic [INDEX_W-1:0] BLOCK_COUNT_RST = 8'd254;
  localparam logic [INDEX_W-1:0] BLOCK_COUNT_MIN = 8'd1;
  localparam logic [INDEX_W-1:0] BLOCK_COUNT_MAX = 8'd254;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_OWNED = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // Write request into the link memory.
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] addr;
    logic [INDEX_W-1:0] data;
  } link_wr_t;

  // Registered read result of the link memory.
  typedef struct packed {
    logic               written;
    logic [INDEX_W-1:0] link;
  } link_rd_t;

  // Link of an entry that was not written since the list was rebuilt.
  function automatic logic [INDEX_W-1:0] default_link(input logic [INDEX_W-1:0] idx,
                                                      input logic [INDEX_W-1:0] count);
    logic [INDEX_W-1:0] res;
    if (idx == count - 8'd1) begin
      res = END_INDEX;
    end else begin
      res = idx + 8'd1;
    end
    return res;
  endfunction

  function automatic logic [INDEX_W-1:0] clamp_count(input logic [INDEX_W-1:0] v);
    logic [INDEX_W-1:0] res;
    if (v < BLOCK_COUNT_MIN) begin
      res = BLOCK_COUNT_MIN;
    end else if (v > BLOCK_COUNT_MAX) begin
      res = BLOCK_COUNT_MAX;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/indexed_free_list_allocator.sv
// Indexed free-list allocator: pops and pushes block indices on a linked list
// kept in a link memory. Depends on ifla_pkg and ifla_link_ram.
// Free: result registered at the accept edge; another may enter unless the output stalls.
// Allocate: the head's link is read into a register, then ST_LOOKUP loads the result.
// Reset and a block_count write rebuild the list at once: head 0, all blocks free.
`default_nettype none

module indexed_free_list_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ifla_pkg::INDEX_W-1:0]   block_count,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           opcode,
  input  wire logic [ifla_pkg::INDEX_W-1:0]   block_index,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [ifla_pkg::STATUS_W-1:0]       status,
  output logic [ifla_pkg::INDEX_W-1:0]        granted_index,
  output logic [ifla_pkg::INDEX_W-1:0]        free_blocks
);

  ifla_pkg::state_t state, state_next;

  logic [ifla_pkg::INDEX_W-1:0] pool_size;
  logic [ifla_pkg::INDEX_W-1:0] head_index, head_index_next;
  logic [ifla_pkg::INDEX_W-1:0] free_count, free_count_next;
  logic                         alloc_ok, alloc_ok_next;

  logic in_accept;
  logic cfg_write;
  logic slot_free;
  logic out_load;
  logic [ifla_pkg::STATUS_W-1:0] status_next;
  logic [ifla_pkg::INDEX_W-1:0]  granted_next;
  logic [ifla_pkg::INDEX_W-1:0]  free_blocks_next;

  ifla_pkg::link_wr_t link_wr;
  ifla_pkg::link_rd_t link_rd;
  logic               link_rd_en;
  logic [ifla_pkg::INDEX_W-1:0] head_link;

  ifla_link_ram u_link_ram (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_write),
    .wr      (link_wr),
    .rd_en   (link_rd_en),
    .rd_addr (head_index),
    .rd      (link_rd)
  );

  assign slot_free = !out_valid || !out_stall;
  // An allocate may enter while a result waits; a free completes at once and needs the slot.
  assign in_stall  = (state != ifla_pkg::ST_IDLE) ||
                     (out_valid && out_stall && (opcode == ifla_pkg::OP_FREE));
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = (state == ifla_pkg::ST_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;

  assign head_link = link_rd.written ? link_rd.link
                                     : ifla_pkg::default_link(head_index, pool_size);

  always_comb begin
    state_next = state;
    case (state)
      ifla_pkg::ST_IDLE: begin
        if (in_accept && (opcode == ifla_pkg::OP_ALLOC)) begin
          state_next = ifla_pkg::ST_LOOKUP;
        end
      end
      ifla_pkg::ST_LOOKUP: begin
        if (slot_free) begin
          state_next = ifla_pkg::ST_IDLE;
        end
      end
      default: state_next = ifla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_index_next  = head_index;
    free_count_next  = free_count;
    alloc_ok_next    = alloc_ok;
    link_wr          = '0;
    link_rd_en       = 1'b0;
    out_load         = 1'b0;
    status_next      = ifla_pkg::STAT_OK;
    granted_next     = '0;
    free_blocks_next = free_count;
    case (state)
      ifla_pkg::ST_IDLE: begin
        if (in_accept && (opcode == ifla_pkg::OP_ALLOC)) begin
          alloc_ok_next = (free_count != '0) && (head_index < pool_size);
          link_rd_en    = alloc_ok_next;
        end else if (in_accept) begin
          out_load = 1'b1;
          if (block_index >= pool_size) begin
            status_next = ifla_pkg::STAT_NOT_OWNED;
          end else begin
            link_wr.en      = 1'b1;
            link_wr.addr    = block_index;
            link_wr.data    = head_index;
            head_index_next = block_index;
            if (free_count != ifla_pkg::COUNT_MAX) begin
              free_count_next = free_count + 8'd1;
            end
            free_blocks_next = free_count_next;
          end
        end
      end
      ifla_pkg::ST_LOOKUP: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (alloc_ok) begin
            granted_next     = head_index;
            head_index_next  = head_link;
            free_count_next  = free_count - 8'd1;
            free_blocks_next = free_count_next;
          end else begin
            status_next = ifla_pkg::STAT_EMPTY;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ifla_pkg::ST_IDLE;
      pool_size  <= ifla_pkg::BLOCK_COUNT_RST;
      head_index <= '0;
      free_count <= ifla_pkg::BLOCK_COUNT_RST;
      alloc_ok   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      alloc_ok <= alloc_ok_next;
      if (cfg_write) begin
        pool_size  <= ifla_pkg::clamp_count(block_count);
        head_index <= '0;
        free_count <= ifla_pkg::clamp_count(block_count);
      end else begin
        head_index <= head_index_next;
        free_count <= free_count_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= status_next;
      granted_index <= granted_next;
      free_blocks   <= free_blocks_next;
    end
  end

  // Hold the head while an allocate waits for the output slot.
  assert property (@(posedge clk) disable iff (rst)
    (state == ifla_pkg::ST_LOOKUP && !slot_free) |=> $stable(head_index))
    else $error("head moved while allocate was waiting");

  assert property (@(posedge clk) disable iff (rst)
    (state == ifla_pkg::ST_IDLE && in_accept && opcode == ifla_pkg::OP_ALLOC)
      |=> (state == ifla_pkg::ST_LOOKUP))
    else $error("allocate did not start a link lookup");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(granted_index) && $stable(status)))
    else $error("pending result overwritten");

  assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (head_index == '0 && free_count == pool_size))
    else $error("list not rebuilt after block count write");

  assert property (@(posedge clk) disable iff (rst)
    (state == ifla_pkg::ST_LOOKUP && slot_free && alloc_ok)
      |=> (free_count == $past(free_count) - 8'd1))
    else $error("free count not decremented on allocate");

endmodule

`default_nettype wire

FILE: design/ifla_link_ram.sv
// Link memory of the free list: one synchronous write and one registered read,
// with a written bit per entry so a rebuild clears the list at once. Uses ifla_pkg.
`default_nettype none

module ifla_link_ram (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire ifla_pkg::link_wr_t            wr,
  input  wire logic                          rd_en,
  input  wire logic [ifla_pkg::INDEX_W-1:0]  rd_addr,
  output ifla_pkg::link_rd_t                 rd
);

  logic [ifla_pkg::INDEX_W-1:0] mem [ifla_pkg::LINK_DEPTH];
  logic [ifla_pkg::LINK_DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd.link    <= mem[rd_addr];
      rd.written <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: verif/indexed_free_list_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_free_list_allocator: directed table then random
// alloc/free traffic, each result checked against its pinned table reply or else against
// a free-list predictor kept here. Depends on ifla_pkg and the allocator RTL.

module indexed_free_list_allocator_test;
  import ifla_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted;
    logic [INDEX_W-1:0]  free_cnt;
  } reply_t;

  // Reply typed into the directed table, or none.
  typedef struct packed {
    logic   pinned;
    reply_t reply;
  } pin_t;

  typedef enum logic {
    ROW_CFG,
    ROW_REQ
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               op;
    logic [INDEX_W-1:0] arg;
    pin_t               pin;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [INDEX_W-1:0]  block_count = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                opcode = OP_ALLOC;
  logic [INDEX_W-1:0]  block_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  granted_index;
  logic [INDEX_W-1:0]  free_blocks;

  // Free-list predictor state
  logic [INDEX_W-1:0] pool_link [0:LINK_DEPTH-1];
  logic [INDEX_W-1:0] pool_head;
  logic [INDEX_W-1:0] pool_free;
  logic [INDEX_W-1:0] pool_size;

  reply_t             due_replies[$];
  pin_t               pinned_replies[$];
  logic [INDEX_W-1:0] handed_out[$];
  int                 mismatches = 0;
  int                 send_gap_pct = 27;
  int                 recv_stall_pct = 87;

  indexed_free_list_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .block_count   (block_count),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .block_index   (block_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .granted_index (granted_index),
    .free_blocks   (free_blocks)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic rebuild_pool(input logic [INDEX_W-1:0] raw);
    int i;
    if (raw < BLOCK_COUNT_MIN) begin
      pool_size = BLOCK_COUNT_MIN;
    end else if (raw > BLOCK_COUNT_MAX) begin
      pool_size = BLOCK_COUNT_MAX;
    end else begin
      pool_size = raw;
    end
    for (i = 0; i < LINK_DEPTH; i++) begin
      pool_link[i] = (i == pool_size - 1) ? END_INDEX : INDEX_W'(i + 1);
    end
    pool_head = '0;
    pool_free = pool_size;
    handed_out.delete();
  endtask

  function automatic reply_t serve_request(input logic op, input logic [INDEX_W-1:0] idx);
    reply_t r;
    r = '{status: STAT_OK, granted: '0, free_cnt: '0};
    if (op == OP_ALLOC) begin
      if (pool_free == 0 || pool_head >= pool_size) begin
        r.status = STAT_EMPTY;
      end else begin
        r.granted = pool_head;
        pool_head = pool_link[pool_head];
        pool_free = pool_free - 8'd1;
      end
    end else if (idx >= pool_size) begin
      r.status = STAT_NOT_OWNED;
    end else begin
      pool_link[idx] = pool_head;
      pool_head = idx;
      // Double frees are pushed again; count saturates
      if (pool_free != COUNT_MAX) pool_free = pool_free + 8'd1;
    end
    r.free_cnt = pool_free;
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t pred;
    reply_t want;
    pin_t   pin;
    if (rst) begin
      rebuild_pool(BLOCK_COUNT_RST);
    end else begin
      if (cfg_valid && cfg_ready) rebuild_pool(block_count);
      if (in_valid && !in_stall) begin
        pred = serve_request(opcode, block_index);
        pin = pinned_replies.pop_front();
        due_replies.push_back(pin.pinned ? pin.reply : pred);
        if (opcode == OP_ALLOC && pred.status == STAT_OK) handed_out.push_back(pred.granted);
      end
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          $display("%0t: unexpected result status=%0d granted=%0d free=%0d",
                   $time, status, granted_index, free_blocks);
          mismatches++;
        end else begin
          want = due_replies.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
          end
          if (granted_index !== want.granted) begin
            $display("%0t: granted_index expected %0d actual %0d",
                     $time, want.granted, granted_index);
            mismatches++;
          end
          if (free_blocks !== want.free_cnt) begin
            $display("%0t: free_blocks expected %0d actual %0d",
                     $time, want.free_cnt, free_blocks);
            mismatches++;
          end
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with in_valid still high.
  task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx, input pin_t pin);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    pinned_replies.push_back(pin);
    in_valid    <= 1'b1;
    opcode      <= op;
    block_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every awaited result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_block_count(input logic [INDEX_W-1:0] value);
    drain();
    cfg_valid   <= 1'b1;
    block_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    stim_row_t          rows[$];
    stim_row_t          row;
    pin_t               no_pin;
    logic [INDEX_W-1:0] idx;
    int                 seg;
    int                 n;
    int                 pos;
    int                 alloc_pct;
    no_pin = '0;

    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   '{1'b1, '{STAT_OK, 8'd0, 8'd253}}});
    rows.push_back('{ROW_REQ, OP_FREE,  8'd254, '{1'b1, '{STAT_NOT_OWNED, 8'd0, 8'd253}}});
    rows.push_back('{ROW_REQ, OP_FREE,  8'd0,   '{1'b1, '{STAT_OK, 8'd0, 8'd254}}});
    rows.push_back('{ROW_REQ, OP_FREE,  8'd0,   '{1'b1, '{STAT_OK, 8'd0, 8'd255}}});
    rows.push_back('{ROW_REQ, OP_FREE,  8'd0,   '{1'b1, '{STAT_OK, 8'd0, 8'd255}}});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   no_pin});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd255 - 8'd1, no_pin});
    rows.push_back('{ROW_CFG, OP_ALLOC, 8'd1,   no_pin});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   '{1'b1, '{STAT_OK, 8'd0, 8'd0}}});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   '{1'b1, '{STAT_EMPTY, 8'd0, 8'd0}}});
    rows.push_back('{ROW_REQ, OP_FREE,  8'd1,   '{1'b1, '{STAT_NOT_OWNED, 8'd0, 8'd0}}});
    rows.push_back('{ROW_REQ, OP_FREE,  8'd0,   '{1'b1, '{STAT_OK, 8'd0, 8'd1}}});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   '{1'b1, '{STAT_OK, 8'd0, 8'd0}}});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   '{1'b1, '{STAT_EMPTY, 8'd0, 8'd0}}});
    // Zero count is raised to one block
    rows.push_back('{ROW_CFG, OP_ALLOC, 8'd0,   no_pin});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   '{1'b1, '{STAT_OK, 8'd0, 8'd0}}});
    // All-ones count is cut to the largest pool
    rows.push_back('{ROW_CFG, OP_ALLOC, 8'd255, no_pin});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   '{1'b1, '{STAT_OK, 8'd0, 8'd253}}});
    rows.push_back('{ROW_REQ, OP_FREE,  8'd253, '{1'b1, '{STAT_OK, 8'd0, 8'd254}}});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   no_pin});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   no_pin});
    rows.push_back('{ROW_CFG, OP_ALLOC, 8'd3,   no_pin});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   '{1'b1, '{STAT_OK, 8'd0, 8'd2}}});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   '{1'b1, '{STAT_OK, 8'd1, 8'd1}}});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   '{1'b1, '{STAT_OK, 8'd2, 8'd0}}});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   '{1'b1, '{STAT_EMPTY, 8'd0, 8'd0}}});
    rows.push_back('{ROW_REQ, OP_FREE,  8'd2,   '{1'b1, '{STAT_OK, 8'd0, 8'd1}}});
    rows.push_back('{ROW_REQ, OP_FREE,  8'd3,   '{1'b1, '{STAT_NOT_OWNED, 8'd0, 8'd1}}});
    rows.push_back('{ROW_REQ, OP_ALLOC, 8'd0,   no_pin});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_CFG) begin
        write_block_count(row.arg);
      end else begin
        send_request(row.op, row.arg, row.pin);
      end
    end

    for (seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin send_gap_pct = 27; recv_stall_pct = 87; end
        1: begin send_gap_pct = 87; recv_stall_pct = 27; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      for (n = 0; n < 316; n++) begin
        if (n % 80 == 0) begin
          case ($urandom_range(9))
            0: idx = 8'd0;
            1: idx = 8'd255;
            2: idx = BLOCK_COUNT_MAX;
            3: idx = BLOCK_COUNT_MIN;
            4, 5, 6, 7: idx = INDEX_W'($urandom_range(2, 12));
            default: idx = INDEX_W'($urandom_range(0, 255));
          endcase
          write_block_count(idx);
          alloc_pct = $urandom_range(30, 70);
        end else if (n % 80 == 40) begin
          drain();
        end
        if ($urandom_range(99) < alloc_pct) begin
          send_request(OP_ALLOC, INDEX_W'($urandom_range(0, 254)), no_pin);
        end else if (handed_out.size() != 0 && $urandom_range(99) < 85) begin
          // Return a block that is out, in random order
          pos = $urandom_range(handed_out.size() - 1);
          idx = handed_out[pos];
          handed_out.delete(pos);
          send_request(OP_FREE, idx, no_pin);
        end else begin
          send_request(OP_FREE, INDEX_W'($urandom_range(0, 254)), no_pin);
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("indexed_free_list_allocator_test: clean");
    end else begin
      $display("indexed_free_list_allocator_test: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("indexed_free_list_allocator_test: errors");
    $finish;
  end

endmodule

FILE: sim.f
design/ifla_pkg.sv
design/ifla_link_ram.sv
design/indexed_free_list_allocator.sv
verif/indexed_free_list_allocator_test.sv
